// File: hw/rtl/nsv_pkg.sv
// Shared types and constants for the nearest-site pixel colorer.
package nsv_pkg;

  localparam int SITE_CNT_W = 9;
  localparam int INDEX_W    = 8;
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int MARKER_REACH = 2;

  localparam logic [COLOR_W-1:0] MARKER_COLOR = 32'hFF00_0000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_ENABLE = 1'b1;

  typedef struct packed {
    logic                  vld;
    logic                  last;
    logic [SITE_CNT_W-1:0] idx;
  } nsv_tag_t;

endpackage

// File: hw/rtl/nsv_site_mem.sv
// Site table: one write port, one registered read port.
module nsv_site_mem import nsv_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 56
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/nsv_dist_pipe.sv
// Two-stage squared-distance pipeline: abs diffs, then squares; sum at output.
module nsv_dist_pipe import nsv_pkg::*; #(
  parameter int CB = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nsv_tag_t           in_tag,
  input  logic [CB-1:0]      site_col,
  input  logic [CB-1:0]      site_row,
  input  logic [COLOR_W-1:0] site_color,
  input  logic [CB-1:0]      px,
  input  logic [CB-1:0]      py,
  output nsv_tag_t           out_tag,
  output logic [2*CB:0]      out_dsq,
  output logic               out_near,
  output logic [COLOR_W-1:0] out_color
);

  localparam int SQW = 2 * CB;
  localparam int DSW = 2 * CB + 1;

  logic [CB-1:0]      dx_nxt, dy_nxt;
  logic               near_nxt;
  nsv_tag_t           tag1_r, tag2_r;
  logic [CB-1:0]      dx_r, dy_r;
  logic               near1_r, near2_r;
  logic [COLOR_W-1:0] color1_r, color2_r;
  logic [SQW-1:0]     dxsq_r, dysq_r;

  always_comb begin
    dx_nxt   = (px > site_col) ? (px - site_col) : (site_col - px);
    dy_nxt   = (py > site_row) ? (py - site_row) : (site_row - py);
    near_nxt = (dx_nxt <= CB'(MARKER_REACH)) && (dy_nxt <= CB'(MARKER_REACH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    near1_r  <= near_nxt;
    color1_r <= site_color;
    dxsq_r   <= SQW'(dx_r) * SQW'(dx_r);
    dysq_r   <= SQW'(dy_r) * SQW'(dy_r);
    near2_r  <= near1_r;
    color2_r <= color1_r;
  end

  assign out_tag   = tag2_r;
  assign out_dsq   = DSW'(dxsq_r) + DSW'(dysq_r);
  assign out_near  = near2_r;
  assign out_color = color2_r;

endmodule

// File: hw/rtl/nearest_site_voronoi_pixel_top.sv
// Nearest-site pixel colorer: site table, scan sequencer and best-site tracking.
//
// Usage:
//   Input channel (in_valid/in_ready) carries either a site load or a pixel
//   query. A load writes one table slot in the beat cycle and gives no result.
//   A query scans slots 0..n-1 and returns one beat on the output
//   channel (out_valid/out_ready): color of the nearest site, its index,
//   a marker flag and a no-site flag.
//   Scan: n = min(site_count, MAX_SITES); the table is read one entry per
//   cycle through its single read port, so n sets the scan length; the
//   distance pipeline then drains and the result is registered. With n = 0
//   the scan is skipped. One query is in flight at a time; in_ready is high
//   while the scan engine is idle, also while a finished result waits on
//   out_ready. A new query whose result is ready before the old one is taken
//   holds until it is.
//   Reset (rst_n low, synchronous): site_count = 0, marker_enable = 1, no
//   result pending. Table contents are undefined until loaded.
//   Config writes (cfg_we) take effect at once; write only while idle.
module nearest_site_voronoi_pixel_top import nsv_pkg::*; #(
  parameter int MAX_SITES  = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SITE_CNT_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [INDEX_W-1:0]    in_site_index,
  input  logic [COORD_BITS-1:0] in_site_x,
  input  logic [COORD_BITS-1:0] in_site_y,
  input  logic [CHAN_W-1:0]     in_chan0,
  input  logic [CHAN_W-1:0]     in_chan1,
  input  logic [CHAN_W-1:0]     in_chan2,
  input  logic [CHAN_W-1:0]     in_chan3,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAN_W-1:0]     out_chan0,
  output logic [CHAN_W-1:0]     out_chan1,
  output logic [CHAN_W-1:0]     out_chan2,
  output logic [CHAN_W-1:0]     out_chan3,
  output logic [INDEX_W-1:0]    out_nearest_index,
  output logic                  out_is_marker,
  output logic                  out_no_site
);

  localparam int CB  = COORD_BITS;
  localparam int AW  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int MW  = COLOR_W + 2 * CB;
  localparam int DSW = 2 * CB + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [SITE_CNT_W-1:0] site_count_r;
  logic                  marker_en_r;
  logic [SITE_CNT_W-1:0] n_r, n_nxt;
  logic [SITE_CNT_W-1:0] scan_idx_r;
  logic [CB-1:0]         px_r, py_r;
  logic                  scan_last;
  logic                  in_fire, load_fire, query_fire, out_load;
  logic                  slot_ok;

  logic [AW+INDEX_W-1:0]    wr_ext;
  logic [AW+SITE_CNT_W-1:0] rd_ext;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [MW-1:0]            wr_data, rd_data;
  logic                     rd_en;

  nsv_tag_t           tag_a_r, pipe_tag;
  logic [DSW-1:0]     pipe_dsq;
  logic               pipe_near;
  logic [COLOR_W-1:0] pipe_color;

  logic                  found_r, marker_r, better;
  logic [DSW-1:0]        best_d_r;
  logic [SITE_CNT_W-1:0] best_idx_r;
  logic [COLOR_W-1:0]    best_color_r, final_color;
  logic                  final_marker;

  logic                  out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]    out_color_r;
  logic [INDEX_W-1:0]    out_idx_r;
  logic                  out_marker_r, out_no_site_r;

  // handshakes
  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (in_operation == OP_LOAD);
  assign query_fire = in_fire && (in_operation == OP_QUERY);
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r <= '0;
      marker_en_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SITE_COUNT:    site_count_r <= cfg_data;
        CFG_MARKER_ENABLE: marker_en_r  <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // table write / read addressing
  assign slot_ok = (32'(in_site_index) < MAX_SITES);
  assign wr_ext  = {{AW{1'b0}}, in_site_index};
  assign wr_addr = wr_ext[AW-1:0];
  assign wr_data = {in_chan3, in_chan2, in_chan1, in_chan0, in_site_y, in_site_x};
  assign rd_ext  = {{AW{1'b0}}, scan_idx_r};
  assign rd_addr = rd_ext[AW-1:0];
  assign rd_en   = (state_r == ST_SCAN);

  nsv_site_mem #(
    .DEPTH (MAX_SITES),
    .AW    (AW),
    .DW    (MW)
  ) u_site_mem (
    .clk     (clk),
    .wr_en   (load_fire && slot_ok),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // scan sequencer
  assign n_nxt     = (32'(site_count_r) > MAX_SITES) ? SITE_CNT_W'(MAX_SITES) : site_count_r;
  assign scan_last = (scan_idx_r == (n_r - SITE_CNT_W'(1)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (query_fire) state_nxt = (n_nxt == '0) ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (pipe_tag.vld && pipe_tag.last) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tag_a_r.vld <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      tag_a_r.vld     <= rd_en;
      tag_a_r.last    <= scan_last;
      tag_a_r.idx     <= scan_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (query_fire) begin
      n_r        <= n_nxt;
      px_r       <= in_pixel_x;
      py_r       <= in_pixel_y;
      scan_idx_r <= '0;
    end else if (rd_en) begin
      scan_idx_r <= scan_idx_r + SITE_CNT_W'(1);
    end
  end

  nsv_dist_pipe #(
    .CB (CB)
  ) u_dist_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tag     (tag_a_r),
    .site_col   (rd_data[CB-1:0]),
    .site_row   (rd_data[2*CB-1:CB]),
    .site_color (rd_data[MW-1:2*CB]),
    .px         (px_r),
    .py         (py_r),
    .out_tag    (pipe_tag),
    .out_dsq    (pipe_dsq),
    .out_near   (pipe_near),
    .out_color  (pipe_color)
  );

  // best-site tracking, strict less keeps the lowest index on ties
  assign better = !found_r || (pipe_dsq < best_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      marker_r <= 1'b0;
    end else if (query_fire) begin
      found_r  <= 1'b0;
      marker_r <= 1'b0;
    end else if (pipe_tag.vld) begin
      found_r  <= 1'b1;
      marker_r <= marker_r || pipe_near;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_tag.vld && better) begin
      best_d_r     <= pipe_dsq;
      best_idx_r   <= pipe_tag.idx;
      best_color_r <= pipe_color;
    end
  end

  // output register
  assign final_marker = marker_en_r && marker_r;
  assign final_color  = final_marker ? MARKER_COLOR : best_color_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (found_r) begin
        out_color_r   <= final_color;
        out_idx_r     <= best_idx_r[INDEX_W-1:0];
        out_marker_r  <= final_marker;
        out_no_site_r <= 1'b0;
      end else begin
        out_color_r   <= '0;
        out_idx_r     <= '0;
        out_marker_r  <= 1'b0;
        out_no_site_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chan0         = out_color_r[7:0];
  assign out_chan1         = out_color_r[15:8];
  assign out_chan2         = out_color_r[23:16];
  assign out_chan3         = out_color_r[31:24];
  assign out_nearest_index = out_idx_r;
  assign out_is_marker     = out_marker_r;
  assign out_no_site       = out_no_site_r;

endmodule
